@@ rtl/mtc_rx_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI time code receiver package
// Byte codes, sysex format codes and the sysex control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_rx_pkg;

	localparam logic [7:0] MIDI_QUARTER_FRAME = 8'hF1;
	localparam logic [7:0] MIDI_SYSEX_START   = 8'hF0;
	localparam logic [7:0] MIDI_SYSEX_END     = 8'hF7;
	localparam logic [7:0] SX_UNIVERSAL_RT    = 8'h7F;
	localparam logic [7:0] SX_SHORT_SUB_ID    = 8'h01;
	localparam logic [7:0] SX_LONG_SUB_ID     = 8'h06;
	localparam logic [7:0] SX_LONG_COMMAND    = 8'h44;
	localparam logic [7:0] PIECE_MASK_FULL    = 8'hFF;

	localparam int unsigned SX_POS_W = 4;
	localparam logic [SX_POS_W-1:0] SX_POS_MAX = '1;

	typedef enum logic [1:0] {
		SX_UNDECIDED = 2'd0,
		SX_SHORT     = 2'd1,
		SX_LONG      = 2'd2,
		SX_REJECTED  = 2'd3
	} sx_fmt_t;

	typedef struct packed {
		sx_fmt_t fmt;
		logic    clr_offset;
		logic    ld_hour;
		logic    ld_rate;
		logic    ld_minute;
		logic    ld_second;
		logic    ld_frame;
	} sx_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mtc_rx_sysex.sv @@
// ----------------------------------------------------------------------------
// MIDI time code receiver sysex decoder
// Checks one byte of a running universal real-time sysex against the short
// and long full-timecode headers and tells which published field it loads.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_rx_sysex
	import mtc_rx_pkg::*;
(
	input  wire logic [7:0]          data,
	input  wire logic [SX_POS_W-1:0] pos,
	input  wire sx_fmt_t             fmt,
	output sx_ctl_t                  ctl
);

	logic reject;

	always_comb begin
		ctl = '0;
		ctl.fmt = fmt;
		reject = 1'b0;
		if (fmt == SX_REJECTED) begin
			reject = 1'b1;
		end else if (pos < 4'd2 && data != SX_UNIVERSAL_RT) begin
			reject = 1'b1;
		end else if (pos < 4'd3 && fmt != SX_UNDECIDED) begin
			reject = 1'b1;
		end else if (pos == 4'd2) begin
			if (data == SX_SHORT_SUB_ID) begin
				ctl.fmt = SX_SHORT;
			end
			if (data == SX_LONG_SUB_ID) begin
				ctl.fmt = SX_LONG;
			end
			ctl.clr_offset = 1'b1;
		end else if (pos > 4'd2 && fmt == SX_UNDECIDED) begin
			reject = 1'b1;
		end else if (fmt == SX_SHORT) begin
			case (pos)
				4'd3: reject = (data != SX_SHORT_SUB_ID);
				4'd4: begin
					ctl.ld_hour = 1'b1;
					ctl.ld_rate = 1'b1;
				end
				4'd5: ctl.ld_minute = 1'b1;
				4'd6: ctl.ld_second = 1'b1;
				4'd7: ctl.ld_frame = 1'b1;
				default: reject = (pos > 4'd7);
			endcase
		end else if (fmt == SX_LONG) begin
			case (pos)
				4'd3: reject = (data != SX_LONG_COMMAND);
				4'd4: reject = (data != SX_LONG_SUB_ID);
				4'd5: reject = (data != SX_SHORT_SUB_ID);
				4'd6: ctl.ld_hour = 1'b1;
				4'd7: ctl.ld_minute = 1'b1;
				4'd8: ctl.ld_second = 1'b1;
				4'd9: ctl.ld_frame = 1'b1;
				default: reject = (pos > 4'd9);
			endcase
		end
		if (reject) begin
			ctl.fmt = SX_REJECTED;
		end
	end

endmodule

`default_nettype wire

@@ rtl/midi_timecode_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// MIDI time code receiver
// Decodes quarter-frame messages and full-timecode sysex messages from a raw
// MIDI byte stream and reports the published timecode after every byte.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   input    in_valid, in_stall   midi_byte
//   output   out_valid, out_stall hours, minutes, seconds, frames, rate_code,
//                                 quarter_offset, locked, quarter_taken
//
// Each byte is decoded in the cycle of its transfer and its result appears in
// the output register on the next cycle, one byte per clock unless stalled.
// The decoder state doubles as the output register, so a byte is taken
// whenever the output register is empty or is being read in the same cycle.
// Reset clears all state; the first result follows the first transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_timecode_receiver_unit
	import mtc_rx_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        midi_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [4:0]             hours,
	output logic [7:0]             minutes,
	output logic [7:0]             seconds,
	output logic [7:0]             frames,
	output logic [1:0]             rate_code,
	output logic signed [4:0]      quarter_offset,
	output logic                   locked,
	output logic                   quarter_taken
);

	logic                in_xfer;
	logic                out_valid_q;
	logic                qf_pending_q;
	logic [7:0]          asm_frame_q, asm_second_q, asm_minute_q;
	logic [4:0]          asm_hour_q;
	logic [1:0]          asm_rate_q;
	logic [2:0]          cur_piece_q, prev_piece_q;
	logic [7:0]          piece_mask_q;
	logic [4:0]          out_hour_q;
	logic [7:0]          out_minute_q, out_second_q, out_frame_q;
	logic [1:0]          out_rate_q;
	logic [4:0]          out_offset_q;
	logic                sx_active_q;
	logic [SX_POS_W-1:0] sx_position_q;
	sx_fmt_t             sx_format_q;
	logic                taken_q;

	logic [7:0]          asm_frame_n, asm_second_n, asm_minute_n;
	logic [4:0]          asm_hour_n;
	logic [1:0]          asm_rate_n;
	logic [2:0]          cur_piece_n, prev_piece_n;
	logic [7:0]          piece_mask_n;
	logic [4:0]          out_hour_n;
	logic [7:0]          out_minute_n, out_second_n, out_frame_n;
	logic [1:0]          out_rate_n;
	logic [4:0]          out_offset_n;
	logic                sx_active_n;
	logic [SX_POS_W-1:0] sx_position_n;
	sx_fmt_t             sx_format_n;
	logic                taken_n;
	logic [2:0]          piece;
	logic [2:0]          step;
	logic                sx_live;
	sx_ctl_t             sx_ctl;

	assign in_stall = out_valid_q & out_stall;
	assign in_xfer  = in_valid & ~in_stall;

	mtc_rx_sysex u_sysex (
		.data (midi_byte),
		.pos  (sx_position_q),
		.fmt  (sx_format_q),
		.ctl  (sx_ctl)
	);

	always_comb begin
		asm_frame_n   = asm_frame_q;
		asm_second_n  = asm_second_q;
		asm_minute_n  = asm_minute_q;
		asm_hour_n    = asm_hour_q;
		asm_rate_n    = asm_rate_q;
		cur_piece_n   = cur_piece_q;
		prev_piece_n  = prev_piece_q;
		piece_mask_n  = piece_mask_q;
		out_hour_n    = out_hour_q;
		out_minute_n  = out_minute_q;
		out_second_n  = out_second_q;
		out_frame_n   = out_frame_q;
		out_rate_n    = out_rate_q;
		out_offset_n  = out_offset_q;
		sx_active_n   = sx_active_q;
		sx_position_n = sx_position_q;
		sx_format_n   = sx_format_q;
		taken_n       = 1'b0;
		piece         = midi_byte[6:4];
		step          = 3'd0;

		if (qf_pending_q && !midi_byte[7]) begin
			taken_n      = 1'b1;
			prev_piece_n = cur_piece_q;
			cur_piece_n  = piece + 3'd1;
			piece_mask_n = piece_mask_q | (8'd1 << cur_piece_n);
			case (piece)
				3'd0: asm_frame_n[3:0]  = midi_byte[3:0];
				3'd1: asm_frame_n[7:4]  = midi_byte[3:0];
				3'd2: asm_second_n[3:0] = midi_byte[3:0];
				3'd3: asm_second_n[7:4] = midi_byte[3:0];
				3'd4: asm_minute_n[3:0] = midi_byte[3:0];
				3'd5: asm_minute_n[7:4] = midi_byte[3:0];
				3'd6: asm_hour_n[3:0]   = midi_byte[3:0];
				default: begin
					asm_hour_n[4] = midi_byte[0];
					asm_rate_n    = midi_byte[2:1];
					if (piece_mask_n == PIECE_MASK_FULL) begin
						out_hour_n   = asm_hour_n;
						out_minute_n = asm_minute_n;
						out_second_n = asm_second_n;
						out_frame_n  = asm_frame_n;
						out_rate_n   = asm_rate_n;
						asm_hour_n   = '0;
						asm_minute_n = '0;
						asm_second_n = '0;
						asm_frame_n  = '0;
						asm_rate_n   = '0;
						cur_piece_n  = '0;
					end
				end
			endcase
			step = cur_piece_n - prev_piece_n;
			if (piece_mask_n != PIECE_MASK_FULL) begin
				out_offset_n = '0;
			end else if (step == 3'd7) begin
				out_offset_n = 5'd0 - {2'b00, cur_piece_n};
			end else if (step == 3'd1) begin
				out_offset_n = {2'b00, cur_piece_n} + 5'd7;
			end else begin
				piece_mask_n = '0;
				out_offset_n = '0;
			end
		end

		// A status byte other than sysex start or end aborts a running sysex.
		sx_live = sx_active_q && !(midi_byte[7] && midi_byte != MIDI_SYSEX_END
			&& midi_byte != MIDI_SYSEX_START);
		sx_active_n = sx_live;
		if (midi_byte == MIDI_SYSEX_END) begin
			sx_active_n = 1'b0;
		end else if (!sx_live && midi_byte == MIDI_SYSEX_START) begin
			sx_active_n   = 1'b1;
			sx_position_n = '0;
			sx_format_n   = SX_UNDECIDED;
		end else if (sx_live) begin
			sx_format_n = sx_ctl.fmt;
			if (sx_ctl.clr_offset) begin
				out_offset_n = '0;
			end
			if (sx_ctl.ld_hour) begin
				out_hour_n = midi_byte[4:0];
			end
			if (sx_ctl.ld_rate) begin
				out_rate_n = midi_byte[6:5];
			end
			if (sx_ctl.ld_minute) begin
				out_minute_n = {1'b0, midi_byte[6:0]};
			end
			if (sx_ctl.ld_second) begin
				out_second_n = {1'b0, midi_byte[6:0]};
			end
			if (sx_ctl.ld_frame) begin
				out_frame_n = {1'b0, midi_byte[6:0]};
			end
			if (sx_position_q != SX_POS_MAX) begin
				sx_position_n = sx_position_q + SX_POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			qf_pending_q  <= 1'b0;
			asm_frame_q   <= '0;
			asm_second_q  <= '0;
			asm_minute_q  <= '0;
			asm_hour_q    <= '0;
			asm_rate_q    <= '0;
			cur_piece_q   <= '0;
			prev_piece_q  <= '0;
			piece_mask_q  <= '0;
			out_hour_q    <= '0;
			out_minute_q  <= '0;
			out_second_q  <= '0;
			out_frame_q   <= '0;
			out_rate_q    <= '0;
			out_offset_q  <= '0;
			sx_active_q   <= 1'b0;
			sx_position_q <= '0;
			sx_format_q   <= SX_UNDECIDED;
			taken_q       <= 1'b0;
		end else begin
			out_valid_q <= in_xfer | (out_valid_q & out_stall);
			if (in_xfer) begin
				qf_pending_q  <= (midi_byte == MIDI_QUARTER_FRAME);
				asm_frame_q   <= asm_frame_n;
				asm_second_q  <= asm_second_n;
				asm_minute_q  <= asm_minute_n;
				asm_hour_q    <= asm_hour_n;
				asm_rate_q    <= asm_rate_n;
				cur_piece_q   <= cur_piece_n;
				prev_piece_q  <= prev_piece_n;
				piece_mask_q  <= piece_mask_n;
				out_hour_q    <= out_hour_n;
				out_minute_q  <= out_minute_n;
				out_second_q  <= out_second_n;
				out_frame_q   <= out_frame_n;
				out_rate_q    <= out_rate_n;
				out_offset_q  <= out_offset_n;
				sx_active_q   <= sx_active_n;
				sx_position_q <= sx_position_n;
				sx_format_q   <= sx_format_n;
				taken_q       <= taken_n;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign hours          = out_hour_q;
	assign minutes        = out_minute_q;
	assign seconds        = out_second_q;
	assign frames         = out_frame_q;
	assign rate_code      = out_rate_q;
	assign quarter_offset = out_offset_q;
	assign locked         = (piece_mask_q == PIECE_MASK_FULL);
	assign quarter_taken  = taken_q;

endmodule

`default_nettype wire
